FILE: hdl/fps_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// fps_pkg
// Shared types and codes for the binary indexed tree prefix-sum block.
// -----------------------------------------------------------------------------
package fps_pkg;

  localparam int unsigned PosW   = 11;
  localparam int unsigned DeltaW = 32;
  localparam int unsigned SumW   = 64;

  localparam logic MODE_UPDATE = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  typedef struct packed {
    logic                     mode;
    logic [PosW-1:0]          position;
    logic signed [DeltaW-1:0] delta;
  } in_t;

  typedef struct packed {
    logic signed [SumW-1:0] prefix_sum;
    logic                   error;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture a new item
    logic clr;       // write zero at the clear pointer
    logic step;      // read the current node, advance the index
    logic out_load;  // move the finished result into the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_range;  // index points at a node inside the tree
    logic rd_vld;    // read data of the previous step is being consumed
    logic clr_last;  // clear pointer on the last entry
  } sts_t;

endpackage : fps_pkg
`default_nettype wire

FILE: hdl/fps_dp.sv
`default_nettype none
// -----------------------------------------------------------------------------
// fps_dp
// Node store, index walker, accumulator and output register.
// -----------------------------------------------------------------------------
module fps_dp
  import fps_pkg::*;
#(
  parameter int unsigned SIZE = 1024
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  cmd_t cmd_i,
  input  in_t  in_data_i,
  output sts_t sts_o,
  output out_t out_data_o
);

  localparam int unsigned AW   = $clog2(SIZE);
  localparam int unsigned NW   = $clog2(SIZE + 1);
  localparam int unsigned IdxW = ((NW > PosW) ? NW : PosW) + 1;
  localparam logic [IdxW-1:0] SizeIdx  = IdxW'(SIZE);
  localparam logic [AW-1:0]   LastAddr = AW'(SIZE - 1);

  logic [SumW-1:0] mem [SIZE];

  logic [IdxW-1:0] idx_q, idx_d;
  logic            mode_q;
  logic [SumW-1:0] delta_q;
  logic [SumW-1:0] acc_q;
  logic            err_q;
  logic [AW-1:0]   wr_addr_q;
  logic [SumW-1:0] rdata_q;
  logic            rd_vld_q;
  logic [AW-1:0]   clr_cnt_q;
  out_t            out_q;

  logic [IdxW-1:0] pos_ext;
  logic [IdxW-1:0] lsb;
  logic [IdxW-1:0] idx_m1;
  logic            over;

  assign pos_ext = IdxW'(in_data_i.position);
  assign over    = pos_ext > SizeIdx;
  assign lsb     = idx_q & (~idx_q + IdxW'(1));
  assign idx_m1  = idx_q - IdxW'(1);

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.load) begin
      idx_d = (in_data_i.mode == MODE_QUERY && over) ? SizeIdx : pos_ext;
    end else if (cmd_i.step) begin
      idx_d = (mode_q == MODE_UPDATE) ? idx_q + lsb : idx_q - lsb;
    end
  end

  // control-side registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q  <= 1'b0;
      clr_cnt_q <= '0;
    end else begin
      rd_vld_q <= cmd_i.step;
      if (cmd_i.clr) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (cmd_i.load) begin
      mode_q  <= in_data_i.mode;
      delta_q <= {{(SumW-DeltaW){in_data_i.delta[DeltaW-1]}}, in_data_i.delta};
      acc_q   <= '0;
      err_q   <= (in_data_i.mode == MODE_UPDATE) ? (in_data_i.position == '0) : over;
    end else if (rd_vld_q && mode_q == MODE_QUERY) begin
      acc_q <= acc_q + rdata_q;
    end
    if (cmd_i.step) begin
      wr_addr_q <= idx_m1[AW-1:0];
    end
    if (cmd_i.out_load) begin
      out_q.prefix_sum <= acc_q;
      out_q.error      <= err_q;
    end
  end

  // node store: one read, one write per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      rdata_q <= mem[idx_m1[AW-1:0]];
    end
    if (cmd_i.clr) begin
      mem[clr_cnt_q] <= '0;
    end else if (rd_vld_q && mode_q == MODE_UPDATE) begin
      mem[wr_addr_q] <= rdata_q + delta_q;
    end
  end

  assign sts_o.in_range = (idx_q != '0) && (idx_q <= SizeIdx);
  assign sts_o.rd_vld   = rd_vld_q;
  assign sts_o.clr_last = clr_cnt_q == LastAddr;
  assign out_data_o     = out_q;

endmodule : fps_dp
`default_nettype wire

FILE: hdl/fps_ctrl.sv
`default_nettype none
// -----------------------------------------------------------------------------
// fps_ctrl
// Sequencer: clearing pass, item accept, tree walk and result hand-off.
// -----------------------------------------------------------------------------
module fps_ctrl
  import fps_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  wire  out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_WALK;
        end
      end
      ST_WALK: begin
        if (sts_i.in_range) begin
          cmd_o.step = 1'b1;
        end else if (!sts_i.rd_vld && (!out_valid_q || out_ready_i)) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;

endmodule : fps_ctrl
`default_nettype wire

FILE: hdl/fenwick_prefix_sum.sv
`default_nettype none
// -----------------------------------------------------------------------------
// fenwick_prefix_sum
// Binary indexed tree: point updates and prefix-sum queries over SIZE nodes.
// -----------------------------------------------------------------------------
// Each item walks n nodes of the tree, n at most log2(SIZE)+1, i.e. 11 for
//   SIZE = 1024. The next item is taken only after the result of the last one
//   has entered the output register, which waits while an earlier result is
//   still held there.
// Reset: asynchronous, active low; afterwards a clearing pass zeroes the store,
//   one entry per cycle while in_ready_o stays low.
// -----------------------------------------------------------------------------
module fenwick_prefix_sum
  import fps_pkg::*;
#(
  parameter int unsigned SIZE = 1024
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  // item input
  input  wire  in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  // result output
  output logic out_valid_o,
  input  wire  out_ready_i,
  output out_t out_data_o
);

  // The controller sequences each item: after the transfer it issues one
  // node read per cycle while the walk index is inside the tree. The
  // datapath consumes the read data in the following cycle (read-modify-write for
  // updates, accumulation for queries), so the write of one node overlaps
  // the read of the next. Nodes of one walk are distinct, so no hazard.
  // The result lands in an output register, freeing the input side for
  // the next transfer while the result waits.

  cmd_t cmd;
  sts_t sts;

  fps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fps_dp #(
    .SIZE (SIZE)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule : fenwick_prefix_sum
`default_nettype wire

FILE: test/tb_fenwick_prefix_sum.sv
// -----------------------------------------------------------------------------
// tb_fenwick_prefix_sum
// Self-checking bench for the binary indexed tree prefix-sum block: a queue-fed
// driver sends point updates and prefix queries with random gaps, a monitor
// predicts each result from its own copy of the tree and checks every output
// transfer in order while stalling the output at random.
// -----------------------------------------------------------------------------
module tb_fenwick_prefix_sum
  import fps_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TreeSize  = 1024;
  localparam int unsigned MaxIdle   = 17;
  localparam int unsigned RandItems = 1150;
  localparam int unsigned DrainCyc  = 30;
  localparam time         RunLimit  = 4ms;     // slowest correct run is well under 1 ms

  // one pending input transfer: payload, idle cycles before it, and whether the
  // sender waits for all outstanding results before offering it
  typedef struct {
    in_t         item;
    int unsigned gap;
    bit          drain;
  } pending_t;

  logic clk_i     = 1'b0;
  logic rst_ni    = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  pending_t    pending_items[$];
  out_t        expected_results[$];
  logic [63:0] node_sums [1:TreeSize];    // shadow of the tree, 1-based like the nodes
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned mismatches = 0;
  int unsigned total_items;
  int unsigned hold_cnt;
  int unsigned stall_left;

  fenwick_prefix_sum #(
    .SIZE (TreeSize)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #RunLimit;
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction: applies one item to the shadow tree and returns its result.
  // Updates climb by adding the lowest set bit; queries descend by clearing it.
  // ---------------------------------------------------------------------------
  function automatic out_t predict_result(in_t it);
    out_t        res;
    int unsigned idx;
    logic [63:0] addend;
    logic [63:0] acc;
    res = '0;
    acc = '0;
    if (it.mode == MODE_UPDATE) begin
      if (it.position == '0) begin
        res.error = 1'b1;               // update at position zero is rejected
      end else begin
        addend = {{32{it.delta[31]}}, it.delta};
        idx    = 32'(it.position);
        while (idx <= TreeSize) begin   // beyond the tree: nothing touched
          node_sums[idx] = node_sums[idx] + addend;
          idx = idx + (idx & (~idx + 1));
        end
      end
    end else begin
      idx = 32'(it.position);
      if (idx > TreeSize) begin
        idx       = TreeSize;           // clamp to the whole tree and flag it
        res.error = 1'b1;
      end
      while (idx != 0) begin
        acc = acc + node_sums[idx];
        idx = idx - (idx & (~idx + 1));
      end
      res.prefix_sum = acc;
    end
    return res;
  endfunction

  function automatic pending_t make_item(logic mode, int unsigned pos, logic [31:0] delta,
                                         int unsigned gap, bit drain);
    pending_t p;
    p.item.mode     = mode;
    p.item.position = pos[PosW-1:0];
    p.item.delta    = delta;
    p.gap           = gap;
    p.drain         = drain;
    return p;
  endfunction

  task automatic add_pending(input pending_t p);
    pending_items = {pending_items, p};
  endtask

  function automatic int unsigned random_position();
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel == 0)      return 0;
    else if (sel == 1) return $urandom_range(TreeSize + 1, 2047);
    else if (sel == 2) return 1 << $urandom_range(0, 10);       // single-node query walks
    else if (sel == 3) return TreeSize - $urandom_range(0, 3);  // long query walks near the top
    else if (sel < 8)  return $urandom_range(1, 32);            // dense low corner
    else               return $urandom_range(1, TreeSize);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers queued items, holding valid and payload until the transfer.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      in_data    <= '0;
      hold_cnt   <= 0;
      items_sent <= 0;
    end else begin : tx_side
      logic took;
      took = in_valid && in_ready;
      if (took) begin
        items_sent <= items_sent + 1;
      end
      if (in_valid && !took) begin
        // keep offering the same item
      end else if (pending_items.size() == 0) begin
        in_valid <= 1'b0;
      end else if (hold_cnt < pending_items[0].gap) begin
        in_valid <= 1'b0;
        hold_cnt <= hold_cnt + 1;
      end else if (pending_items[0].drain && (took || expected_results.size() != 0)) begin
        in_valid <= 1'b0;                 // wait for every result to come back
      end else begin
        in_valid <= 1'b1;
        in_data  <= pending_items[0].item;
        pending_items.pop_front();
        hold_cnt <= 0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on each input transfer, checks each output transfer,
  // and drives the output ready with random stalls.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready    <= 1'b0;
      stall_left   <= 0;
      results_seen <= 0;
    end else begin : rx_side
      out_t        want;
      int unsigned g;
      if (in_valid && in_ready) begin
        expected_results = {expected_results, predict_result(in_data)};
      end
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, prefix_sum %0d error %0b",
                   $time, out_data.prefix_sum, out_data.error);
          mismatches = mismatches + 1;
        end else begin
          want = expected_results.pop_front();
          if (out_data.prefix_sum !== want.prefix_sum) begin
            $display("%0t: prefix_sum mismatch, expected %0d, got %0d",
                     $time, want.prefix_sum, out_data.prefix_sum);
            mismatches = mismatches + 1;
          end
          if (out_data.error !== want.error) begin
            $display("%0t: error flag mismatch, expected %0b, got %0b",
                     $time, want.error, out_data.error);
            mismatches = mismatches + 1;
          end
        end
        // every fourth block of 64 results runs without output stalls
        g = ((results_seen % 256) < 64) ? 0 : $urandom_range(0, MaxIdle);
        out_ready  <= (g == 0);
        stall_left <= g;
      end else if (!out_ready) begin
        if (stall_left <= 1) begin
          out_ready <= 1'b1;
        end
        if (stall_left != 0) begin
          stall_left <= stall_left - 1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    int unsigned k;
    int unsigned gap;
    logic        mode;
    bit          calm;
    for (int i = 1; i <= TreeSize; i++) begin
      node_sums[i] = '0;
    end

    // directed part: extremes, both operations, and every corner case
    add_pending(make_item(MODE_QUERY,  0,    32'h0, 0, 0));        // empty sum
    add_pending(make_item(MODE_QUERY,  TreeSize, 32'h0, 0, 0));    // fresh tree
    add_pending(make_item(MODE_UPDATE, 0,    32'h7fff_ffff, 0, 0)); // rejected
    add_pending(make_item(MODE_UPDATE, 1,    32'h7fff_ffff, 1, 0));
    add_pending(make_item(MODE_UPDATE, TreeSize, 32'h8000_0000, 0, 0));
    add_pending(make_item(MODE_UPDATE, TreeSize + 1, 32'h1234_5678, 2, 0));
    add_pending(make_item(MODE_UPDATE, 2047, 32'hffff_ffff, 0, 0));  // beyond tree
    add_pending(make_item(MODE_UPDATE, 512,  32'hffff_ffff, 0, 0));
    add_pending(make_item(MODE_UPDATE, 1023, 32'h0000_0001, 3, 0));
    add_pending(make_item(MODE_UPDATE, 1365, 32'h5555_5555, 0, 0));
    add_pending(make_item(MODE_UPDATE, 682,  32'haaaa_aaaa, 0, 0));
    add_pending(make_item(MODE_QUERY,  1,    32'hffff_ffff, 0, 0));
    add_pending(make_item(MODE_QUERY,  511,  32'h0, 0, 0));
    add_pending(make_item(MODE_QUERY,  512,  32'h0, 5, 0));
    add_pending(make_item(MODE_QUERY,  1023, 32'h0, 0, 0));
    add_pending(make_item(MODE_QUERY,  TreeSize, 32'h0, 0, 0));
    add_pending(make_item(MODE_QUERY,  TreeSize + 1, 32'h0, 0, 0)); // clamped
    add_pending(make_item(MODE_QUERY,  2047, 32'h8000_0000, 0, 0));
    add_pending(make_item(MODE_QUERY,  1365, 32'h0, 0, 0));
    add_pending(make_item(MODE_QUERY,  0,    32'h0, MaxIdle, 0));
    add_pending(make_item(MODE_UPDATE, 2,    32'h8000_0000, 0, 0));
    add_pending(make_item(MODE_QUERY,  2,    32'h0, 0, 1));        // after drain

    // random part: queries read back a tree built by random updates
    for (k = 0; k < RandItems; k++) begin
      calm = (k % 300) < 60;             // idle-free stretch on the input side
      gap  = calm ? 0 : $urandom_range(0, MaxIdle);
      mode = ($urandom_range(0, 99) < 45) ? MODE_QUERY : MODE_UPDATE;
      add_pending(make_item(mode, random_position(), $urandom, gap,
                            (k % 250) == 249));
    end
    total_items = pending_items.size();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (items_sent != total_items || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCyc) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_results.size());
      mismatches = mismatches + 1;
    end

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule : tb_fenwick_prefix_sum

FILE: files.f
hdl/fps_pkg.sv
hdl/fps_dp.sv
hdl/fps_ctrl.sv
hdl/fenwick_prefix_sum.sv
test/tb_fenwick_prefix_sum.sv
